[sv/bernoulli_negative_triple_sampler_top_macros.svh]
// Assertion macros for the negative triple sampler.
// Used by the sampler core; no other dependencies.
`ifndef BERNOULLI_NEGATIVE_TRIPLE_SAMPLER_TOP_MACROS_SVH
`define BERNOULLI_NEGATIVE_TRIPLE_SAMPLER_TOP_MACROS_SVH
// implication checked on every edge outside reset
`define BNTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bnts assertion failed");
// next-cycle implication
`define BNTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bnts assertion failed");
`endif

[sv/bnts_pkg.sv]
// Shared types and constants for the negative triple sampler.
// No dependencies.
`default_nettype none
package bnts_pkg;
  localparam int MaxTriples   = 524288;
  localparam int MaxEntities  = 16384;
  localparam int MaxRelations = 2048;
  localparam int MaxBatch     = 64;
  localparam int SlotW = $clog2(MaxTriples);
  localparam int RelW  = $clog2(MaxRelations);
  localparam int EntW  = 14;
  localparam int TcW   = 20;
  localparam int EcW   = 15;
  localparam int ThrW  = 10;
  localparam int BatW  = 7;
  localparam int TripW = 2 * EntW + RelW;
  localparam logic [63:0] LcgMul  = 64'd25214903917;
  localparam logic [63:0] LcgAdd  = 64'd11;
  localparam logic [63:0] RngSeed = 64'd3;
  localparam logic [9:0]  ProbScale = 10'd1000;

  typedef enum logic [1:0] {
    ACT_TRIPLE = 2'd0,
    ACT_THRESH = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    CFG_TRIPLE_COUNT = 1'b0,
    CFG_ENTITY_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_IDX_LCG, ST_IDX_MOD, ST_RD_TRIP, ST_RD_THR, ST_DRAW_LCG,
    ST_DRAW_MOD, ST_ENT_LCG, ST_ENT_MOD, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [EntW-1:0] pos_head;
    logic [RelW-1:0] pos_relation;
    logic [EntW-1:0] pos_tail;
    logic [EntW-1:0] neg_head;
    logic [EntW-1:0] neg_tail;
    logic            last;
  } result_t;

  // handshake between sequencer and modulo unit
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [TcW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [TcW-1:0] rem;
  } mod_rsp_t;
endpackage
`default_nettype wire

[sv/bnts_if.sv]
// Valid/ready channel interfaces carrying the request and result fields.
// Depends on nothing; the field widths are fixed in each interface.
`default_nettype none
interface bnts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [18:0] slot;
  logic [13:0] head_id;
  logic [10:0] relation_id;
  logic [13:0] tail_id;
  logic [9:0]  threshold;
  logic [6:0]  batch_count;
  modport source (output valid, action, slot, head_id, relation_id, tail_id, threshold,
                  batch_count, input ready);
  modport sink (input valid, action, slot, head_id, relation_id, tail_id, threshold,
                batch_count, output ready);
endinterface

interface bnts_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] pos_head;
  logic [10:0] pos_relation;
  logic [13:0] pos_tail;
  logic [13:0] neg_head;
  logic [13:0] neg_tail;
  logic        last;
  modport source (output valid, pos_head, pos_relation, pos_tail, neg_head, neg_tail, last,
                  input ready);
  modport sink (input valid, pos_head, pos_relation, pos_tail, neg_head, neg_tail, last,
                output ready);
endinterface
`default_nettype wire

[sv/bnts_mod.sv]
// Remainder units: a restoring 64-bit by 20-bit divider, one bit per cycle, and a
// three-stage modulo-1000 pipeline that folds the dividend by residues of 2^k.
// Depends on bnts_pkg.
`default_nettype none
module bnts_mod (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bnts_pkg::mod_req_t req,
  output bnts_pkg::mod_rsp_t     rsp
);
  import bnts_pkg::*;

  logic [63:0]    div_r, div_nxt;
  logic [TcW:0]   rem_r, rem_nxt;
  logic [TcW-1:0] dsr_r, dsr_nxt;
  logic [6:0]     cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [TcW+1:0] trial;

  // shift one dividend bit into the partial remainder, subtract if it fits
  always_comb begin
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, div_r[63]} - {2'b00, dsr_r};
    if (req.start) begin
      div_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      div_nxt = {div_r[62:0], 1'b0};
      if (!trial[TcW+1]) rem_nxt = trial[TcW:0];
      else               rem_nxt = {rem_r[TcW-1:0], div_r[63]};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[TcW-1:0];
endmodule

// Modulo 1000 in three register stages; start is delayed through v1_r and v2_r into done.
// 2^16, 2^32, 2^48 are 536, 296, 656 mod 1000; 2^10 is 24 mod 1000.
module bnts_mod1k (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [63:0]            dividend,
  output logic                        done,
  output logic [bnts_pkg::ThrW-1:0]   rem
);
  import bnts_pkg::*;

  logic [26:0]     s1_r, s1_nxt;
  logic [15:0]     s2_r, s2_nxt;
  logic [ThrW-1:0] rem_r, rem_nxt;
  logic            v1_r, v2_r, done_r;
  logic [20:0]     f1;
  logic [11:0]     f3;

  // fold 16-bit digits, then 10-bit digits, then a final conditional subtract
  always_comb begin
    s1_nxt = 27'(dividend[63:48]) * 27'd656 + 27'(dividend[47:32]) * 27'd296
           + 27'(dividend[31:16]) * 27'd536 + 27'(dividend[15:0]);
    f1     = 21'(s1_r[26:16]) * 21'd536 + 21'(s1_r[15:0]);
    s2_nxt = 16'(f1[20:10]) * 16'd24 + 16'(f1[9:0]);
    f3     = 12'(s2_r[15:10]) * 12'd24 + 12'(s2_r[9:0]);
    if (f3 >= 12'(2 * ProbScale))  rem_nxt = ThrW'(f3 - 12'(2 * ProbScale));
    else if (f3 >= 12'(ProbScale)) rem_nxt = ThrW'(f3 - 12'(ProbScale));
    else                           rem_nxt = ThrW'(f3);
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

[sv/bnts_core.sv]
// Sampler sequencer: triple and threshold memories, LCG state, result register.
// Depends on bnts_pkg, bnts_mod, bnts_mod1k and the macros header.
`default_nettype none
`include "bernoulli_negative_triple_sampler_top_macros.svh"
module bnts_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire bnts_pkg::action_t      in_action,
  input  wire logic [18:0]            in_slot,
  input  wire logic [13:0]            in_head_id,
  input  wire logic [10:0]            in_relation_id,
  input  wire logic [13:0]            in_tail_id,
  input  wire logic [9:0]             in_threshold,
  input  wire logic [6:0]             in_batch_count,
  input  wire logic [bnts_pkg::TcW-1:0] tc_eff,
  input  wire logic [bnts_pkg::EcW-1:0] ec_eff,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output bnts_pkg::result_t           out_res
);
  import bnts_pkg::*;

  // storage
  logic [TripW-1:0] trip_mem [MaxTriples];
  logic [ThrW-1:0]  thr_mem  [MaxRelations];
  logic [TripW-1:0] trip_q;
  logic [ThrW-1:0]  thr_q;
  logic [SlotW-1:0] trip_ra;
  logic [RelW-1:0]  thr_ra;

  state_t st_r, st_nxt;
  logic [63:0]    rng_r, rng_nxt;
  logic [63:0]    pp_lo_r, pp_lo_nxt;
  logic [31:0]    pp_x_r, pp_x_nxt;
  logic [6:0]     left_r, left_nxt;
  logic [TripW-1:0] trip_r, trip_nxt;
  logic [ThrW-1:0]  thr_r, thr_nxt;
  logic [SlotW-1:0] idx_r, idx_nxt;
  logic [EntW-1:0]  ent_r, ent_nxt;
  logic           tail_r, tail_nxt;
  logic           ovalid_r, ovalid_nxt;
  result_t        res_r, res_nxt;
  mod_req_t       mreq;
  mod_rsp_t       mrsp;
  logic           k_start;
  logic           k_done;
  logic [ThrW-1:0] k_rem;
  logic [6:0]     n_sat;
  logic           acc;

  bnts_mod u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  bnts_mod1k u_mod1k (
    .clk(clk), .rst_n(rst_n), .start(k_start), .dividend(rng_nxt),
    .done(k_done), .rem(k_rem)
  );

  assign acc   = in_valid && in_ready;
  assign n_sat = (in_batch_count > 7'(MaxBatch)) ? 7'(MaxBatch) : in_batch_count;

  // memory writes on load requests; registered reads
  always_ff @(posedge clk) begin
    if (acc && in_action == ACT_TRIPLE)
      trip_mem[in_slot] <= {in_head_id, in_relation_id, in_tail_id};
    if (acc && in_action == ACT_THRESH)
      thr_mem[in_relation_id] <= in_threshold;
    trip_q <= trip_mem[trip_ra];
    thr_q  <= thr_mem[thr_ra];
  end

  assign trip_ra = idx_r;
  assign thr_ra  = trip_q[EntW +: RelW];

  // LCG partial products from the settled state; rng only moves in LCG steps,
  // which always have at least one other state between them
  assign pp_lo_nxt = 64'(rng_r[31:0]) * 64'(LcgMul[31:0]);
  assign pp_x_nxt  = rng_r[63:32] * LcgMul[31:0] + rng_r[31:0] * LcgMul[63:32];

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:     if (acc && in_action == ACT_SAMPLE && n_sat != 7'd0) st_nxt = ST_IDX_LCG;
      ST_IDX_LCG:  st_nxt = ST_IDX_MOD;
      ST_IDX_MOD:  if (mrsp.done) st_nxt = ST_RD_TRIP;
      ST_RD_TRIP:  st_nxt = ST_RD_THR;
      ST_RD_THR:   st_nxt = ST_DRAW_LCG;
      ST_DRAW_LCG: st_nxt = ST_DRAW_MOD;
      ST_DRAW_MOD: if (k_done) st_nxt = ST_ENT_LCG;
      ST_ENT_LCG:  st_nxt = ST_ENT_MOD;
      ST_ENT_MOD:  if (mrsp.done) st_nxt = ST_EMIT;
      ST_EMIT:     if (!ovalid_r || out_ready)
                     st_nxt = (left_r == 7'd1) ? ST_IDLE : ST_IDX_LCG;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rng_nxt    = rng_r;
    left_nxt   = left_r;
    trip_nxt   = trip_r;
    thr_nxt    = thr_r;
    idx_nxt    = idx_r;
    ent_nxt    = ent_r;
    tail_nxt   = tail_r;
    res_nxt    = res_r;
    ovalid_nxt = ovalid_r && !out_ready;
    mreq       = '0;
    k_start    = 1'b0;
    in_ready   = (st_r == ST_IDLE);
    case (st_r)
      ST_IDLE: if (acc && in_action == ACT_SAMPLE) left_nxt = n_sat;
      ST_IDX_LCG, ST_ENT_LCG: begin
        rng_nxt        = pp_lo_r + {pp_x_r, 32'h0} + LcgAdd;
        mreq.start     = 1'b1;
        mreq.dividend  = rng_nxt;
        mreq.divisor   = (st_r == ST_IDX_LCG) ? tc_eff : TcW'(ec_eff);
      end
      ST_DRAW_LCG: begin
        rng_nxt = pp_lo_r + {pp_x_r, 32'h0} + LcgAdd;
        k_start = 1'b1;
        thr_nxt = thr_q;
      end
      ST_IDX_MOD: if (mrsp.done) idx_nxt = mrsp.rem[SlotW-1:0];
      ST_RD_THR:  trip_nxt = trip_q;
      ST_DRAW_MOD: if (k_done) tail_nxt = (k_rem < thr_r);
      ST_ENT_MOD: if (mrsp.done) ent_nxt = mrsp.rem[EntW-1:0];
      ST_EMIT: if (!ovalid_r || out_ready) begin
        res_nxt.pos_head     = trip_r[EntW+RelW +: EntW];
        res_nxt.pos_relation = trip_r[EntW +: RelW];
        res_nxt.pos_tail     = trip_r[EntW-1:0];
        res_nxt.neg_head     = tail_r ? trip_r[EntW+RelW +: EntW] : ent_r;
        res_nxt.neg_tail     = tail_r ? ent_r : trip_r[EntW-1:0];
        res_nxt.last         = (left_r == 7'd1);
        ovalid_nxt = 1'b1;
        left_nxt   = left_r - 7'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    trip_r  <= trip_nxt;
    thr_r   <= thr_nxt;
    idx_r   <= idx_nxt;
    ent_r   <= ent_nxt;
    tail_r  <= tail_nxt;
    pp_lo_r <= pp_lo_nxt;
    pp_x_r  <= pp_x_nxt;
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      rng_r    <= RngSeed;
      left_r   <= '0;
      ovalid_r <= 1'b0;
      res_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      rng_r    <= rng_nxt;
      left_r   <= left_nxt;
      ovalid_r <= ovalid_nxt;
      res_r    <= res_nxt;
    end
  end

  assign out_valid = ovalid_r;
  assign out_res   = res_r;

  `BNTS_ASSERT_IMP(a_idle_ready, in_ready, st_r == ST_IDLE)
  `BNTS_ASSERT_NXT(a_hold_result, out_valid && !out_ready, $stable(out_res))
  `BNTS_ASSERT_IMP(a_mod_no_overlap, mreq.start, !mrsp.busy)
  `BNTS_ASSERT_IMP(a_emit_left, st_r == ST_EMIT, left_r != 7'd0)
endmodule
`default_nettype wire

[sv/bernoulli_negative_triple_sampler_top.sv]
// Negative triple sampler: holds triples and per-relation thresholds; a sample
// request yields batch_count results of (true triple, corrupted head/tail, last).
// Channels: in_* valid/ready request channel (load triple, load threshold, sample),
// out_* valid/ready result channel, cfg_* plain write port (0 triple_count,
// 1 entity_count); the user writes it only while idle, which the block does not enforce.
// Loads are written when accepted; batch_count is capped at 64. Each sample costs
// three LCG steps, two remainders in a bit-serial divider, the modulo-1000
// pipeline, two memory reads and an emit step. A new request is taken only once
// the last result of a batch has entered the output register.
// Reset (synchronous, rst_n low) sets the generator to 3, triple_count to 1
// and entity_count to 16384; memories keep contents and need no clearing.
// A stalled receiver holds the result register; the sequencer waits in its
// emit step until the register frees.
// Depends on bnts_pkg, bnts_if, bnts_core and bnts_mod.
`default_nettype none
module bernoulli_negative_triple_sampler_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bnts_in_if.sink          in_ch,
  bnts_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [19:0] cfg_wdata
);
  import bnts_pkg::*;

  logic [TcW-1:0] tc_r;
  logic [EcW-1:0] ec_r;
  logic [TcW-1:0] tc_eff;
  logic [EcW-1:0] ec_eff;
  result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= TcW'(1);
      ec_r <= EcW'(MaxEntities);
    end else if (cfg_we) begin
      if (cfg_index == CFG_TRIPLE_COUNT) tc_r <= cfg_wdata[TcW-1:0];
      else                                ec_r <= cfg_wdata[EcW-1:0];
    end
  end

  // saturate counts into their legal ranges
  assign tc_eff = (tc_r == '0) ? TcW'(1) : (tc_r > TcW'(MaxTriples)) ? TcW'(MaxTriples) : tc_r;
  assign ec_eff = (ec_r == '0) ? EcW'(1) : (ec_r > EcW'(MaxEntities)) ? EcW'(MaxEntities) : ec_r;

  bnts_core u_core (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_action(action_t'(in_ch.action)), .in_slot(in_ch.slot),
    .in_head_id(in_ch.head_id), .in_relation_id(in_ch.relation_id),
    .in_tail_id(in_ch.tail_id), .in_threshold(in_ch.threshold),
    .in_batch_count(in_ch.batch_count),
    .tc_eff(tc_eff), .ec_eff(ec_eff),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  assign out_ch.pos_head     = res.pos_head;
  assign out_ch.pos_relation = res.pos_relation;
  assign out_ch.pos_tail     = res.pos_tail;
  assign out_ch.neg_head     = res.neg_head;
  assign out_ch.neg_tail     = res.neg_tail;
  assign out_ch.last         = res.last;
endmodule
`default_nettype wire
